/* design/dotb_pkg.sv */
// ----------------------------------------------------------------------------
// dotb_pkg - shared types and constants for the deadline-ordered timer bank
// Transaction kind codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package dotb_pkg;

    // Transaction kinds carried in tuser of the input stream
    typedef enum logic [1:0] {
        KIND_PERIOD = 2'd0,
        KIND_START  = 2'd1,
        KIND_STOP   = 2'd2,
        KIND_TICK   = 2'd3
    } t_kind;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_DECIDE = 2'd2,
        ST_FLUSH  = 2'd3
    } t_state;

    localparam int ID_W        = 4;   // timer_id / expired_id width
    localparam int VAL_W       = 32;  // period, delay, deadline, counters
    localparam int MAX_REPORTS = 16;  // expiries reported per tick at most
    localparam int CNT_W       = 5;   // holds 0 .. MAX_REPORTS

endpackage

/* design/deadline_ordered_timer_bank_unit.sv */
// ----------------------------------------------------------------------------
// deadline_ordered_timer_bank_unit - bank of timer slots with ordered expiry
// Slots are programmed and ticked over one input stream; each tick reports
// its expired slots on the output stream in deadline order.
// ----------------------------------------------------------------------------
// Set period / start / stop transactions are taken while the sequencer is idle. A tick
// holds the input off while it scans: one pass over S = min(NUM_TIMERS, 16) slots per
// expiry plus a final pass, or a flush step in place of the last pass once 16 are reported;
// one shared compare unit walks the slots one per cycle for every pass. Output
// back-pressure stalls the sequencer. Reset (synchronous, active low): count, start
// sequence, periods and active flags cleared, sequencer idle, output stream empty.
// ----------------------------------------------------------------------------
module deadline_ordered_timer_bank_unit #(
    parameter int NUM_TIMERS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [3:0] timer_id, [35:4] value, [39:36] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] kind
    // Output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [3:0] expired_id, [7:4] zero
    output logic        o_m_axis_tlast    // last expiry of this tick
);

    // Only ids 0..15 can be addressed, so no more than 16 slots are stored.
    localparam int SLOTS = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // ------------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------------
    dotb_pkg::t_state r_state, n_state;

    logic [dotb_pkg::VAL_W-1:0] r_now;            // tick count
    logic [dotb_pkg::VAL_W-1:0] r_seq;            // start sequence
    logic [dotb_pkg::VAL_W-1:0] r_deadline [SLOTS];
    logic [dotb_pkg::VAL_W-1:0] r_stamp    [SLOTS];
    logic [dotb_pkg::VAL_W-1:0] r_period   [SLOTS];
    logic [SLOTS-1:0]           r_active;
    logic [SLOTS-1:0]           r_done;           // already reported this tick

    // Scan bookkeeping
    logic [IDX_W-1:0]            r_idx;
    logic                        r_found;
    logic [IDX_W-1:0]            r_best;
    logic [dotb_pkg::VAL_W-1:0]  r_best_dl;
    logic [dotb_pkg::VAL_W-1:0]  r_best_stamp;
    logic [dotb_pkg::CNT_W-1:0]  r_count;

    // One expiry held back until it is known whether it closes the tick
    logic                        r_pend_valid;
    logic [IDX_W-1:0]            r_pend_id;

    // Output register
    logic                        r_out_valid;
    logic [dotb_pkg::ID_W-1:0]   r_out_id;
    logic                        r_out_last;

    // ------------------------------------------------------------------------
    // Input field split
    // ------------------------------------------------------------------------
    logic [dotb_pkg::ID_W-1:0]   in_id;
    logic [dotb_pkg::VAL_W-1:0]  in_value;
    dotb_pkg::t_kind             in_kind;
    logic                        in_id_ok;
    logic [IDX_W-1:0]            in_slot;
    logic                        in_accept;

    assign in_id     = i_s_axis_tdata[3:0];
    assign in_value  = i_s_axis_tdata[35:4];
    assign in_kind   = dotb_pkg::t_kind'(i_s_axis_tuser);
    assign in_id_ok  = ({1'b0, in_id} < 5'(SLOTS));
    assign in_slot   = in_id[IDX_W-1:0];
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;

    // ------------------------------------------------------------------------
    // Shared compare unit: examines slot r_idx against the best so far.
    // Ordering is earlier deadline first, then greater age since start.
    // ------------------------------------------------------------------------
    logic [dotb_pkg::VAL_W-1:0] scan_dl;
    logic [dotb_pkg::VAL_W-1:0] age_cand, age_best;
    logic                       cand, goes_before, take;

    assign scan_dl     = r_deadline[r_idx];
    assign age_cand    = r_seq - r_stamp[r_idx];
    assign age_best    = r_seq - r_best_stamp;
    assign cand        = r_active[r_idx] && !r_done[r_idx] && (scan_dl <= r_now);
    assign goes_before = (scan_dl != r_best_dl) ? (scan_dl < r_best_dl)
                                                : (age_cand > age_best);
    assign take        = cand && (!r_found || goes_before);

    logic out_free;
    logic scan_end;
    logic last_report;

    assign out_free    = !r_out_valid || i_m_axis_tready;
    assign scan_end    = (r_idx == IDX_W'(SLOTS - 1));
    assign last_report = (r_count == dotb_pkg::CNT_W'(dotb_pkg::MAX_REPORTS - 1));

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dotb_pkg::ST_IDLE: begin
                if (in_accept && in_kind == dotb_pkg::KIND_TICK) begin
                    n_state = dotb_pkg::ST_SCAN;
                end
            end
            dotb_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = dotb_pkg::ST_DECIDE;
                end
            end
            dotb_pkg::ST_DECIDE: begin
                if (out_free) begin
                    if (!r_found) begin
                        n_state = dotb_pkg::ST_IDLE;
                    end else if (last_report) begin
                        n_state = dotb_pkg::ST_FLUSH;
                    end else begin
                        n_state = dotb_pkg::ST_SCAN;
                    end
                end
            end
            dotb_pkg::ST_FLUSH: begin
                if (out_free) begin
                    n_state = dotb_pkg::ST_IDLE;
                end
            end
            default: n_state = dotb_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------------
    logic                      load_out;
    logic                      load_last;
    logic                      commit;     // retire the scan winner

    always_comb begin
        o_s_axis_tready = 1'b0;
        load_out        = 1'b0;
        load_last       = 1'b0;
        commit          = 1'b0;
        unique case (r_state)
            dotb_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
            end
            dotb_pkg::ST_SCAN: begin
            end
            dotb_pkg::ST_DECIDE: begin
                if (out_free) begin
                    // the held expiry goes out; it closes the tick if nothing new
                    load_out  = r_pend_valid;
                    load_last = !r_found;
                    commit    = r_found;
                end
            end
            dotb_pkg::ST_FLUSH: begin
                if (out_free) begin
                    load_out  = 1'b1;
                    load_last = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dotb_pkg::ST_IDLE;
            r_now        <= '0;
            r_seq        <= '0;
            r_active     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_count      <= '0;
            r_found      <= 1'b0;
        end else begin
            r_state <= n_state;

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                dotb_pkg::ST_IDLE: begin
                    if (in_accept) begin
                        unique case (in_kind)
                            dotb_pkg::KIND_START: begin
                                if (in_id_ok) begin
                                    r_active[in_slot] <= 1'b1;
                                    r_seq             <= r_seq + 1'b1;
                                end
                            end
                            dotb_pkg::KIND_STOP: begin
                                if (in_id_ok) begin
                                    r_active[in_slot] <= 1'b0;
                                end
                            end
                            dotb_pkg::KIND_TICK: begin
                                r_now        <= r_now + 1'b1;
                                r_count      <= '0;
                                r_pend_valid <= 1'b0;
                                r_found      <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                dotb_pkg::ST_SCAN: begin
                    if (take) begin
                        r_found <= 1'b1;
                    end
                end
                dotb_pkg::ST_DECIDE: begin
                    if (commit) begin
                        r_pend_valid <= 1'b1;
                        r_count      <= r_count + 1'b1;
                        r_found      <= 1'b0;
                        if (r_period[r_best] != '0) begin
                            r_seq <= r_seq + 1'b1;
                        end else begin
                            r_active[r_best] <= 1'b0;
                        end
                    end else if (out_free) begin
                        r_pend_valid <= 1'b0;
                    end
                end
                dotb_pkg::ST_FLUSH: begin
                    if (out_free) begin
                        r_pend_valid <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Period store has reset (zero = one-shot)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_period[i] <= '0;
            end
        end else if (r_state == dotb_pkg::ST_IDLE && in_accept
                     && in_kind == dotb_pkg::KIND_PERIOD && in_id_ok) begin
            r_period[in_slot] <= in_value;
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers (no reset)
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        // deadline and start stamp: one write per cycle, start or re-arm
        if (r_state == dotb_pkg::ST_IDLE && in_accept
            && in_kind == dotb_pkg::KIND_START && in_id_ok) begin
            r_deadline[in_slot] <= r_now + in_value;
            r_stamp[in_slot]    <= r_seq;
        end else if (commit && r_period[r_best] != '0) begin
            r_deadline[r_best]  <= r_now + r_period[r_best];
            r_stamp[r_best]     <= r_seq;
        end

        if (r_state == dotb_pkg::ST_IDLE) begin
            r_done <= '0;
            r_idx  <= '0;
        end else if (r_state == dotb_pkg::ST_SCAN) begin
            if (!scan_end) begin
                r_idx <= r_idx + 1'b1;
            end
            if (take) begin
                r_best       <= r_idx;
                r_best_dl    <= scan_dl;
                r_best_stamp <= r_stamp[r_idx];
            end
        end else if (commit) begin
            r_done[r_best] <= 1'b1;
            r_pend_id      <= r_best;
            r_idx          <= '0;
        end

        if (load_out) begin
            r_out_id   <= dotb_pkg::ID_W'(r_pend_id);
            r_out_last <= load_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_id};
    assign o_m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // the output register is never overwritten while a result still waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_out_valid || i_m_axis_tready))
        else $error("output register overwritten");

    // a retired winner was an active slot whose deadline had been reached
    a_winner_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |-> (r_active[r_best] && !r_done[r_best] && r_best_dl <= r_now))
        else $error("retired slot was not due");

    // a tick advances the count by exactly one
    a_tick_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_kind == dotb_pkg::KIND_TICK) |=> (r_now == $past(r_now) + 1'b1))
        else $error("tick count did not advance by one");

    // the flush state always has a held expiry to send
    a_flush_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dotb_pkg::ST_FLUSH) |-> r_pend_valid)
        else $error("flush with no held expiry");

endmodule
